// ===== src/mwo_pkg.sv =====
`default_nettype none
package mwo_pkg;

   // configuration register indexes
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_INV  = 1'b1;

   // waveform modes
   localparam logic [2:0] MODE_SINE   = 3'd0;
   localparam logic [2:0] MODE_SQUARE = 3'd1;
   localparam logic [2:0] MODE_SAW    = 3'd2;
   localparam logic [2:0] MODE_TRI    = 3'd3;
   localparam logic [2:0] MODE_TRIPLE = 3'd4;

   localparam int MUL_WIDTH  = 33;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int DIVD_WIDTH = 34;
   localparam int DIVS_WIDTH = 17;
   localparam int CORDIC_STEPS = 30;

   // floor(2^32 / 3), applied to half the dividend
   localparam logic [31:0] THIRD_RECIP = 32'd1431655765;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

   localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1};

   typedef struct packed {
      logic signed [MUL_WIDTH-1:0] lhs;
      logic signed [MUL_WIDTH-1:0] rhs;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic [DIVD_WIDTH-1:0] dividend;
      logic [DIVD_WIDTH-1:0] estimate;
      logic [DIVD_WIDTH-1:0] prod_est;
      logic [DIVS_WIDTH-1:0] divisor;
   } div_req_type;

endpackage
`default_nettype wire

// ===== src/mwo_mul.sv =====
`default_nettype none
module mwo_mul
   import mwo_pkg::*;
(
   input  wire logic                         clock,
   input  wire mul_req_type                  req,
   output logic signed [PROD_WIDTH-1:0]      prod
);

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;

   assign prod_in = req.lhs * req.rhs;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== src/mwo_div.sv =====
`default_nettype none
module mwo_div
   import mwo_pkg::*;
(
   input  wire div_req_type           req,
   output logic [DIVD_WIDTH-1:0]      quotient
);

   // reciprocal estimate is at most two below the true quotient
   always_comb begin
      logic [DIVD_WIDTH-1:0] rem;
      logic [DIVD_WIDTH-1:0] dvs;
      rem = req.dividend - req.prod_est;
      dvs = DIVD_WIDTH'(req.divisor);
      priority if (rem >= (dvs << 1)) begin
         quotient = req.estimate + DIVD_WIDTH'(2);
      end else if (rem >= dvs) begin
         quotient = req.estimate + DIVD_WIDTH'(1);
      end else begin
         quotient = req.estimate;
      end
   end

endmodule
`default_nettype wire

// ===== src/mwo_cordic.sv =====
`default_nettype none
module mwo_cordic
   import mwo_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cordic_req_type      req,
   output logic                     done,
   output logic signed [32:0]       sine
);

   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [1:0]         quad_ff, quad_in;
   logic [4:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      logic signed [33:0] shx;
      logic signed [33:0] shy;
      logic signed [32:0] at;
      shx     = x_ff >>> step_ff;
      shy     = y_ff >>> step_ff;
      at      = $signed({3'b000, ATAN_TURNS[step_ff]});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = $signed({3'b000, req.angle[29:0]});
         quad_in = req.angle[31:30];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - shy;
            y_in = y_ff + shx;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + shy;
            y_in = y_ff - shx;
            z_in = z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

   // clamp to +-1 and fold the quadrant back
   always_comb begin
      logic signed [33:0] xc;
      logic signed [33:0] yc;
      logic signed [33:0] sel;
      xc = (x_ff > ONE_Q30) ? ONE_Q30 : ((x_ff < -ONE_Q30) ? -ONE_Q30 : x_ff);
      yc = (y_ff > ONE_Q30) ? ONE_Q30 : ((y_ff < -ONE_Q30) ? -ONE_Q30 : y_ff);
      unique case (quad_ff)
         2'd0: sel = yc;
         2'd1: sel = xc;
         2'd2: sel = -yc;
         default: sel = -xc;
      endcase
      sine = sel[32:0];
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== src/multi_waveform_oscillator.sv =====
// sine runs a 30-step cordic, triple peak runs three sines and a reciprocal divide by three;
//   a depth that is not a power of two adds the angle states AQ, AR, AE and AC per sine
// one transaction at a time, taken only in the idle state; a held result stalls the push;
//   the shared multiplier and cordic serve one item, a new item is taken while a result waits
// reset: synchronous active high, clears the sequencer, sample counter and config registers
`default_nettype none
module multi_waveform_oscillator
   import mwo_pkg::*;
#(
   parameter int SAMPLE_WIDTH     = 16,
   parameter int PHASE_WIDTH      = 32,
   parameter int SINE_TABLE_DEPTH = 1024
)(
   input  wire logic        clock,
   input  wire logic        reset,
   // csr write port
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pitch_hz[23:0], gain[38:24], mod_offset[58:39], shape_value[74:59]
   input  wire logic [79:0] req_tdata,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // audio_out[SAMPLE_WIDTH-1:0]
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int OUT_BYTES_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RND_SHIFT   = 46 - SAMPLE_WIDTH;
   localparam bit D_POW2      = (SINE_TABLE_DEPTH & (SINE_TABLE_DEPTH - 1)) == 0;
   localparam int LOG2D       = $clog2(SINE_TABLE_DEPTH);
   localparam int PW          = PHASE_WIDTH;

   // 2^32 = ANG_Q * depth + ANG_R, for the angle of a table index
   localparam logic [32:0] ANG_Q = 33'((64'd1 << 32) / SINE_TABLE_DEPTH);
   localparam logic [32:0] ANG_R = 33'((64'd1 << 32) % SINE_TABLE_DEPTH);

   localparam logic signed [PROD_WIDTH-1:0] SAT_MAX =
      $signed({{(PROD_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [PROD_WIDTH-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [PROD_WIDTH-1:0] RND_HALF =
      $signed(PROD_WIDTH'(1) << (RND_SHIFT - 1));
   localparam logic signed [PROD_WIDTH-1:0] ONE_W = PROD_WIDTH'(ONE_Q30);

   // sequencer states
   typedef enum logic [20:0] {
      ST_IDLE = 21'b000000000000000000001,
      ST_FN   = 21'b000000000000000000010,
      ST_LO   = 21'b000000000000000000100,
      ST_HI   = 21'b000000000000000001000,
      ST_BASE = 21'b000000000000000010000,
      ST_OFF  = 21'b000000000000000100000,
      ST_TOFF = 21'b000000000000001000000,
      ST_PIDX = 21'b000000000000010000000,
      ST_IDX  = 21'b000000000000100000000,
      ST_AQ   = 21'b000000000001000000000,
      ST_AR   = 21'b000000000010000000000,
      ST_AE   = 21'b000000000100000000000,
      ST_AC   = 21'b000000001000000000000,
      ST_COR  = 21'b000000010000000000000,
      ST_S3   = 21'b000000100000000000000,
      ST_D3E  = 21'b000001000000000000000,
      ST_D3C  = 21'b000010000000000000000,
      ST_TRI  = 21'b000100000000000000000,
      ST_GAIN = 21'b001000000000000000000,
      ST_RND  = 21'b010000000000000000000,
      ST_PUSH = 21'b100000000000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] inv_ff, inv_in;
   logic [31:0] count_ff, count_in;

   // latched transaction fields
   logic [23:0]        f_ff, f_in;
   logic [14:0]        a_ff, a_in;
   logic signed [19:0] m_ff, m_in;
   logic [15:0]        s_ff, s_in;

   // working registers
   logic [19:0]        hi_ff, hi_in;
   logic [39:0]        acc_ff, acc_in;
   logic [39:0]        base_ff, base_in;
   logic [39:0]        off_ff, off_in;
   logic [39:0]        kb_ff, kb_in;
   logic [1:0]         harm_ff, harm_in;
   logic signed [33:0] sum_ff, sum_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] v_ff, v_in;
   logic [SAMPLE_WIDTH-1:0] r_ff, r_in;
   logic [16:0]           idx_ff, idx_in;
   logic [31:0]           ahi_ff, ahi_in;
   logic [DIVD_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DIVD_WIDTH-1:0] est_ff, est_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // shared units
   mul_req_type                  mul_req;
   logic signed [PROD_WIDTH-1:0] prod;
   cordic_req_type               cor_req;
   logic                         cor_done;
   logic signed [32:0]           cor_sine;
   div_req_type                  div_req;
   logic [DIVS_WIDTH-1:0]        div_dvs;
   logic [DIVD_WIDTH-1:0]        div_quot;

   mwo_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   mwo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .done  (cor_done),
      .sine  (cor_sine)
   );

   // quotient correction after the reciprocal estimate, divisor three or the depth
   assign div_dvs = (state_ff == ST_D3C) ? DIVS_WIDTH'(3) : DIVS_WIDTH'(SINE_TABLE_DEPTH);
   assign div_req = '{dividend: dvd_ff, estimate: est_ff,
                      prod_est: prod[DIVD_WIDTH-1:0], divisor: div_dvs};

   mwo_div u_div (
      .req      (div_req),
      .quotient (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_BYTES_W'(rsp_data_ff);

   always_comb begin
      logic [39:0]            ph40;
      logic [87:0]            ph_wide;
      logic [PW-1:0]          q;
      logic [PW+29:0]         q_wide;
      logic [29:0]            p30;
      logic [PW+1:0]          thr;
      logic signed [33:0]     u;
      logic signed [PROD_WIDTH-1:0] t;
      logic signed [33:0]     s3w;
      logic signed [33:0]     tot;
      logic [32:0]            dmag;
      logic [47:0]            ang_wide;
      logic signed [PROD_WIDTH-1:0] rr;

      state_in     = state_ff;
      mode_in      = mode_ff;
      inv_in       = inv_ff;
      count_in     = count_ff;
      f_in         = f_ff;
      a_in         = a_ff;
      m_in         = m_ff;
      s_in         = s_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      kb_in        = kb_ff;
      harm_in      = harm_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      ahi_in       = ahi_ff;
      dvd_in       = dvd_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      cor_req      = '0;

      // phase of either path, then truncation to the phase width and to q0.30
      if (state_ff == ST_TOFF) begin
         ph40 = base_ff + {prod[23:0], 16'b0};
      end else begin
         ph40 = kb_ff + off_ff;
      end
      ph_wide = {ph40, 48'b0};
      q       = ph_wide[87 -: PW];
      q_wide  = {q, 30'b0};
      p30     = q_wide[PW+29 -: 30];
      thr     = {s_ff, (PW-14)'(0)};

      // triangle fold: |4p - 2| - 1
      u = $signed({2'b00, p30, 2'b00}) - 34'sd2147483648;
      if (u < 0) begin
         u = -u;
      end
      u = u - ONE_Q30;

      t        = prod >>> 14;
      s3w      = t[33:0];
      tot      = sum_ff + s3w;
      dmag     = tot[33] ? 33'(-tot + 34'sd2) : tot[32:0];
      ang_wide = 48'(prod[46:30]) << (32 - LOG2D);
      rr       = (prod + RND_HALF) >>> RND_SHIFT;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: mode_in = csr_wdata[2:0];
            CSR_INV:  inv_in  = csr_wdata;
            default:  mode_in = mode_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               f_in     = req_tdata[23:0];
               a_in     = req_tdata[38:24];
               m_in     = $signed(req_tdata[58:39]);
               s_in     = req_tdata[74:59];
               state_in = ST_FN;
            end
         end
         ST_FN: begin
            // pitch times sample count
            mul_req.lhs = $signed({9'b0, f_ff});
            mul_req.rhs = $signed({1'b0, count_ff});
            state_in    = ST_LO;
         end
         ST_LO: begin
            hi_in       = prod[39:20];
            mul_req.lhs = $signed({13'b0, prod[19:0]});
            mul_req.rhs = $signed({1'b0, inv_ff});
            state_in    = ST_HI;
         end
         ST_HI: begin
            acc_in      = prod[39:0];
            mul_req.lhs = $signed({13'b0, hi_ff});
            mul_req.rhs = $signed({1'b0, inv_ff});
            state_in    = ST_BASE;
         end
         ST_BASE: begin
            base_in = acc_ff + {prod[19:0], 20'b0};
            priority if (mode_ff == MODE_SINE || mode_ff == MODE_TRIPLE) begin
               // radians to cycles
               mul_req.lhs = 33'(m_ff);
               mul_req.rhs = 33'sd2670177;
               state_in    = ST_OFF;
            end else if (mode_ff == MODE_SQUARE || mode_ff == MODE_SAW ||
                         mode_ff == MODE_TRI) begin
               // time offset times pitch
               mul_req.lhs = $signed({9'b0, f_ff});
               mul_req.rhs = 33'(m_ff);
               state_in    = ST_TOFF;
            end else begin
               // unused mode gives a zero sample
               v_in     = '0;
               state_in = ST_GAIN;
            end
         end
         ST_OFF: begin
            off_in   = prod[39:0];
            kb_in    = base_ff;
            harm_in  = '0;
            sum_in   = '0;
            state_in = ST_PIDX;
         end
         ST_PIDX: begin
            mul_req.lhs = $signed({3'b0, p30});
            mul_req.rhs = 33'(SINE_TABLE_DEPTH);
            state_in    = ST_IDX;
         end
         ST_IDX: begin
            if (D_POW2) begin
               cor_req.start = 1'b1;
               cor_req.angle = ang_wide[31:0];
               state_in      = ST_COR;
            end else begin
               // angle = index * ANG_Q + floor(index * ANG_R / depth)
               idx_in      = prod[46:30];
               mul_req.lhs = $signed({16'b0, prod[46:30]});
               mul_req.rhs = $signed(ANG_Q);
               state_in    = ST_AQ;
            end
         end
         ST_AQ: begin
            ahi_in      = prod[31:0];
            mul_req.lhs = $signed({16'b0, idx_ff});
            mul_req.rhs = $signed(ANG_R);
            state_in    = ST_AR;
         end
         ST_AR: begin
            // reciprocal estimate of the remainder part
            dvd_in      = {2'b0, prod[31:0]};
            mul_req.lhs = $signed({1'b0, prod[31:0]});
            mul_req.rhs = $signed(ANG_Q);
            state_in    = ST_AE;
         end
         ST_AE: begin
            est_in      = DIVD_WIDTH'(prod[57:32]);
            mul_req.lhs = $signed({16'b0, prod[48:32]});
            mul_req.rhs = 33'(SINE_TABLE_DEPTH);
            state_in    = ST_AC;
         end
         ST_AC: begin
            cor_req.start = 1'b1;
            cor_req.angle = ahi_ff + div_quot[31:0];
            state_in      = ST_COR;
         end
         ST_COR: begin
            if (cor_done) begin
               if (mode_ff == MODE_SINE) begin
                  v_in     = cor_sine;
                  state_in = ST_GAIN;
               end else if (harm_ff == 2'd2) begin
                  // third harmonic weight
                  mul_req.lhs = cor_sine;
                  mul_req.rhs = $signed({17'b0, s_ff} + 33'd16384);
                  state_in    = ST_S3;
               end else begin
                  sum_in   = sum_ff + 34'(cor_sine);
                  kb_in    = kb_ff + base_ff;
                  harm_in  = harm_ff + 2'd1;
                  state_in = ST_PIDX;
               end
            end
         end
         ST_S3: begin
            // floor divide by three on the magnitude, half of it times 2^32 / 3
            neg_in      = tot[33];
            dvd_in      = {1'b0, dmag};
            mul_req.lhs = $signed({1'b0, dmag[32:1]});
            mul_req.rhs = $signed({1'b0, THIRD_RECIP});
            state_in    = ST_D3E;
         end
         ST_D3E: begin
            est_in      = DIVD_WIDTH'(prod[62:31]);
            mul_req.lhs = $signed({1'b0, prod[62:31]});
            mul_req.rhs = 33'sd3;
            state_in    = ST_D3C;
         end
         ST_D3C: begin
            v_in     = neg_ff ? -$signed(div_quot[32:0]) : $signed(div_quot[32:0]);
            state_in = ST_GAIN;
         end
         ST_TOFF: begin
            priority if (mode_ff == MODE_SQUARE) begin
               v_in     = ({2'b00, q} > thr) ? 33'(ONE_Q30) : 33'(-ONE_Q30);
               state_in = ST_GAIN;
            end else if (mode_ff == MODE_SAW) begin
               v_in     = 33'(ONE_Q30) - $signed({2'b00, p30, 1'b0});
               state_in = ST_GAIN;
            end else begin
               mul_req.lhs = u[32:0];
               mul_req.rhs = $signed({16'b0, s_ff, 1'b0} + 33'd16384);
               state_in    = ST_TRI;
            end
         end
         ST_TRI: begin
            if (t > ONE_W) begin
               v_in = 33'(ONE_Q30);
            end else if (t < -ONE_W) begin
               v_in = 33'(-ONE_Q30);
            end else begin
               v_in = t[32:0];
            end
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_req.lhs = $signed({18'b0, a_ff});
            mul_req.rhs = v_ff;
            state_in    = ST_RND;
         end
         ST_RND: begin
            // round, shift to sample scale and saturate
            if (rr > SAT_MAX) begin
               r_in = SAT_MAX[SAMPLE_WIDTH-1:0];
            end else if (rr < SAT_MIN) begin
               r_in = SAT_MIN[SAMPLE_WIDTH-1:0];
            end else begin
               r_in = rr[SAMPLE_WIDTH-1:0];
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = r_ff;
               count_in     = count_ff + 32'd1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SINE;
         inv_ff       <= 32'd97391;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         inv_ff       <= inv_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      f_ff        <= f_in;
      a_ff        <= a_in;
      m_ff        <= m_in;
      s_ff        <= s_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      off_ff      <= off_in;
      kb_ff       <= kb_in;
      harm_ff     <= harm_in;
      sum_ff      <= sum_in;
      neg_ff      <= neg_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      idx_ff      <= idx_in;
      ahi_ff      <= ahi_in;
      dvd_ff      <= dvd_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
